### design/rrfp_pkg.sv
// ---------------------------------------------------------------------------
// rrfp_pkg
// Shared types and constants for the radar report frame parser.
// ---------------------------------------------------------------------------
package rrfp_pkg;

    localparam logic [31:0] ACK_HEAD      = 32'hFDFC_FBFA;
    localparam logic [31:0] ACK_TAIL      = 32'h0403_0201;
    localparam logic [31:0] DAT_HEAD      = 32'hF4F3_F2F1;
    localparam logic [31:0] DAT_TAIL      = 32'hF8F7_F6F5;
    localparam logic [15:0] ACK_FLAG      = 16'h0100;
    localparam logic [7:0]  ANGLE_BIAS    = 8'h80;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
    localparam logic [15:0] TAIL_LAST_POS = 16'd3;
    localparam int          TARGET_BYTES  = 5;
    localparam logic [2:0]  TARGET_LAST_BYTE = 3'(TARGET_BYTES - 1);

    typedef enum logic [7:0] {
        ST_HUNT     = 8'b0000_0001,
        ST_LEN_LO   = 8'b0000_0010,
        ST_LEN_HI   = 8'b0000_0100,
        ST_BODY     = 8'b0000_1000,
        ST_TAIL     = 8'b0001_0000,
        ST_EMIT_FIX = 8'b0010_0000,
        ST_EMIT_RD  = 8'b0100_0000,
        ST_EMIT_WR  = 8'b1000_0000
    } state_t;

    // Controller to datapath strobes
    typedef struct packed {
        logic do_hunt;
        logic do_len_lo;
        logic do_len_hi;
        logic do_body;
        logic do_tail;
        logic rd_issue;
        logic load_fixed;
        logic load_target;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic header_hit;
        logic len_too_long;
        logic len_zero;
        logic body_done;
        logic tail_done;
        logic tail_good;
        logic frame_ack;
        logic total_zero;
        logic last_slot;
        logic out_free;
    } sts_t;

endpackage

### design/rrfp_ram.sv
// ---------------------------------------------------------------------------
// rrfp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rrfp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/rrfp_ctrl.sv
// ---------------------------------------------------------------------------
// rrfp_ctrl
// Frame parsing controller: sequences hunt, length, body, tail and emission.
// ---------------------------------------------------------------------------
module rrfp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rx_valid,
    output logic          rx_stall,
    input  rrfp_pkg::sts_t sts,
    output rrfp_pkg::cmd_t cmd
);
    import rrfp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // hold off input while results are being emitted
    assign rx_stall = (state_reg == ST_EMIT_FIX) || (state_reg == ST_EMIT_RD)
                      || (state_reg == ST_EMIT_WR);
    assign accept   = rx_valid && !rx_stall;

    always_comb
    begin
        cmd             = '0;
        cmd.do_hunt     = accept && (state_reg == ST_HUNT);
        cmd.do_len_lo   = accept && (state_reg == ST_LEN_LO);
        cmd.do_len_hi   = accept && (state_reg == ST_LEN_HI);
        cmd.do_body     = accept && (state_reg == ST_BODY);
        cmd.do_tail     = accept && (state_reg == ST_TAIL);
        cmd.rd_issue    = (state_reg == ST_EMIT_RD);
        cmd.load_fixed  = (state_reg == ST_EMIT_FIX) && sts.out_free;
        cmd.load_target = (state_reg == ST_EMIT_WR) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (accept && sts.header_hit)
                begin
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (accept)
                begin
                    state_next = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (accept)
                begin
                    priority if (sts.len_too_long)
                        state_next = ST_HUNT;
                    else if (sts.len_zero)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (accept && sts.body_done)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (accept && sts.tail_done)
                begin
                    priority if (!sts.tail_good)
                        state_next = ST_HUNT;
                    else if (sts.frame_ack || sts.total_zero)
                        state_next = ST_EMIT_FIX;
                    else
                        state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_FIX:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_HUNT;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last_slot ? ST_HUNT : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/rrfp_dp.sv
// ---------------------------------------------------------------------------
// rrfp_dp
// Frame parser datapath: windows, counters, target store and result register.
// ---------------------------------------------------------------------------
module rrfp_dp #(
    parameter int MAX_TARGETS     = 8,
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  rrfp_pkg::cmd_t     cmd,
    output rrfp_pkg::sts_t     sts,
    input  logic               rpt_stall,
    output logic               rpt_valid,
    output logic               frame_kind,
    output logic               alarm_flag,
    output logic [3:0]         target_total,
    output logic [2:0]         target_slot,
    output logic signed [7:0]  target_angle,
    output logic [7:0]         target_range,
    output logic [7:0]         heading_code,
    output logic [7:0]         target_speed,
    output logic [7:0]         snr_value,
    output logic [15:0]        ack_command,
    output logic               ack_ok,
    output logic               last_of_frame
);
    import rrfp_pkg::*;

    localparam int IW = $clog2(MAX_TARGETS + 1);
    localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam logic [IW-1:0] MAX_IDX   = IW'(MAX_TARGETS);
    localparam logic [7:0]    MAX_COUNT = 8'(MAX_TARGETS);
    localparam logic [16:0]   MAX_BYTES = 17'(MAX_FRAME_BYTES);

    // parse state
    logic [31:0] header_window_reg, header_window_next;
    logic        frame_is_ack_reg,  frame_is_ack_next;
    logic [15:0] body_length_reg,   body_length_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [2:0]  sub_byte_reg,      sub_byte_next;
    logic [IW-1:0] target_idx_reg,  target_idx_next;
    logic [7:0]  stored_count_reg,  stored_count_next;
    logic        stored_alarm_reg,  stored_alarm_next;
    logic [15:0] ack_code_reg,      ack_code_next;
    logic [15:0] ack_status_reg,    ack_status_next;
    logic [31:0] tail_window_reg,   tail_window_next;
    logic [IW-1:0] total_reg,       total_next;
    logic [IW-1:0] slot_reg,        slot_next;
    logic        out_valid_reg,     out_valid_next;
    logic [3:0][7:0] target_asm_reg;

    // result register payload
    logic        kind_reg;
    logic        alarm_reg;
    logic [3:0]  total_out_reg;
    logic [2:0]  slot_out_reg;
    logic [7:0]  angle_reg;
    logic [7:0]  distance_reg;
    logic [7:0]  heading_reg;
    logic [7:0]  speed_reg;
    logic [7:0]  snr_reg;
    logic [15:0] ack_cmd_reg;
    logic        ack_ok_reg;
    logic        last_reg;

    logic [31:0]   hw_shift;
    logic [31:0]   tail_shift;
    logic [15:0]   len_full;
    logic [15:0]   pos_inc;
    logic          is_target_byte;
    logic          target_full;
    logic [IW-1:0] count_clamp;
    logic [IW-1:0] total_calc;
    logic          ram_wr_en;
    logic [39:0]   ram_wr_data;
    logic [39:0]   ram_rd_data;

    assign hw_shift   = {header_window_reg[23:0], rx_byte};
    assign tail_shift = {tail_window_reg[23:0], rx_byte};
    assign len_full   = {rx_byte, body_length_reg[7:0]};
    assign pos_inc    = byte_position_reg + 16'd1;
    assign is_target_byte = !frame_is_ack_reg && (byte_position_reg[15:1] != 15'd0);
    assign target_full    = (target_idx_reg == MAX_IDX);

    // clamp the count to the limit and to the complete targets received
    assign count_clamp = (stored_count_reg > MAX_COUNT) ? MAX_IDX : IW'(stored_count_reg);
    assign total_calc  = (count_clamp > target_idx_reg) ? target_idx_reg : count_clamp;

    always_comb
    begin
        sts              = '0;
        sts.header_hit   = (hw_shift == ACK_HEAD) || (hw_shift == DAT_HEAD);
        sts.len_too_long = !frame_is_ack_reg
                           && (({1'b0, len_full} + FRAME_OVERHEAD) > MAX_BYTES);
        sts.len_zero     = (len_full == 16'd0);
        sts.body_done    = (pos_inc >= body_length_reg);
        sts.tail_done    = (byte_position_reg == TAIL_LAST_POS);
        sts.tail_good    = frame_is_ack_reg ? (tail_shift == ACK_TAIL)
                                            : (tail_shift == DAT_TAIL);
        sts.frame_ack    = frame_is_ack_reg;
        sts.total_zero   = (total_calc == '0);
        sts.last_slot    = ((slot_reg + IW'(1)) == total_reg);
        sts.out_free     = !out_valid_reg || !rpt_stall;
    end

    always_comb
    begin
        header_window_next = header_window_reg;
        frame_is_ack_next  = frame_is_ack_reg;
        body_length_next   = body_length_reg;
        byte_position_next = byte_position_reg;
        sub_byte_next      = sub_byte_reg;
        target_idx_next    = target_idx_reg;
        stored_count_next  = stored_count_reg;
        stored_alarm_next  = stored_alarm_reg;
        ack_code_next      = ack_code_reg;
        ack_status_next    = ack_status_reg;
        tail_window_next   = tail_window_reg;
        total_next         = total_reg;
        slot_next          = slot_reg;

        if (cmd.do_hunt)
        begin
            header_window_next = hw_shift;
            if (sts.header_hit)
            begin
                frame_is_ack_next  = (hw_shift == ACK_HEAD);
                stored_count_next  = 8'd0;
                stored_alarm_next  = 1'b0;
                ack_code_next      = 16'd0;
                ack_status_next    = 16'd0;
                byte_position_next = 16'd0;
            end
        end

        if (cmd.do_len_lo)
        begin
            body_length_next = {8'd0, rx_byte};
        end

        if (cmd.do_len_hi)
        begin
            body_length_next = len_full;
            if (sts.len_too_long)
            begin
                // drop and restart hunting with this byte
                header_window_next = {24'd0, rx_byte};
            end
            else
            begin
                byte_position_next = 16'd0;
                tail_window_next   = 32'd0;
                sub_byte_next      = 3'd0;
                target_idx_next    = '0;
            end
        end

        if (cmd.do_body)
        begin
            byte_position_next = sts.body_done ? 16'd0 : pos_inc;
            if (frame_is_ack_reg)
            begin
                priority if (byte_position_reg == 16'd0)
                    ack_code_next[7:0] = rx_byte;
                else if (byte_position_reg == 16'd1)
                    ack_code_next[15:8] = rx_byte;
                else if (byte_position_reg == 16'd2)
                    ack_status_next[7:0] = rx_byte;
                else if (byte_position_reg == 16'd3)
                    ack_status_next[15:8] = rx_byte;
                else
                    ack_status_next = ack_status_reg;
            end
            else if (byte_position_reg == 16'd0)
            begin
                stored_count_next = rx_byte;
            end
            else if (byte_position_reg == 16'd1)
            begin
                stored_alarm_next = (rx_byte != 8'd0);
            end
            else if (sub_byte_reg == TARGET_LAST_BYTE)
            begin
                sub_byte_next = 3'd0;
                if (!target_full)
                begin
                    target_idx_next = target_idx_reg + IW'(1);
                end
            end
            else
            begin
                sub_byte_next = sub_byte_reg + 3'd1;
            end
        end

        if (cmd.do_tail)
        begin
            tail_window_next   = tail_shift;
            byte_position_next = sts.tail_done ? 16'd0 : pos_inc;
            total_next         = total_calc;
            slot_next          = '0;
            if (sts.tail_done)
            begin
                header_window_next = sts.tail_good ? 32'd0 : {24'd0, rx_byte};
            end
        end

        if (cmd.load_target)
        begin
            slot_next = slot_reg + IW'(1);
        end
    end

    always_comb
    begin
        priority if (cmd.load_fixed || cmd.load_target)
            out_valid_next = 1'b1;
        else if (!rpt_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_window_reg <= 32'd0;
            frame_is_ack_reg  <= 1'b0;
            body_length_reg   <= 16'd0;
            byte_position_reg <= 16'd0;
            sub_byte_reg      <= 3'd0;
            target_idx_reg    <= '0;
            stored_count_reg  <= 8'd0;
            stored_alarm_reg  <= 1'b0;
            ack_code_reg      <= 16'd0;
            ack_status_reg    <= 16'd0;
            tail_window_reg   <= 32'd0;
            total_reg         <= '0;
            slot_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            header_window_reg <= header_window_next;
            frame_is_ack_reg  <= frame_is_ack_next;
            body_length_reg   <= body_length_next;
            byte_position_reg <= byte_position_next;
            sub_byte_reg      <= sub_byte_next;
            target_idx_reg    <= target_idx_next;
            stored_count_reg  <= stored_count_next;
            stored_alarm_reg  <= stored_alarm_next;
            ack_code_reg      <= ack_code_next;
            ack_status_reg    <= ack_status_next;
            tail_window_reg   <= tail_window_next;
            total_reg         <= total_next;
            slot_reg          <= slot_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // assemble the first four target bytes; the fifth completes the entry
    always_ff @(posedge clk)
    begin
        if (cmd.do_body && is_target_byte && (sub_byte_reg != TARGET_LAST_BYTE))
        begin
            target_asm_reg[sub_byte_reg[1:0]] <= rx_byte;
        end
    end

    assign ram_wr_en   = cmd.do_body && is_target_byte
                         && (sub_byte_reg == TARGET_LAST_BYTE) && !target_full;
    assign ram_wr_data = {rx_byte, target_asm_reg};

    rrfp_ram #(
        .WIDTH (40),
        .DEPTH (MAX_TARGETS),
        .AW    (AW)
    ) u_target_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (target_idx_reg[AW-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (slot_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_fixed)
        begin
            kind_reg      <= frame_is_ack_reg;
            alarm_reg     <= frame_is_ack_reg ? 1'b0 : stored_alarm_reg;
            total_out_reg <= 4'd0;
            slot_out_reg  <= 3'd0;
            angle_reg     <= 8'd0;
            distance_reg  <= 8'd0;
            heading_reg   <= 8'd0;
            speed_reg     <= 8'd0;
            snr_reg       <= 8'd0;
            ack_cmd_reg   <= frame_is_ack_reg ? (ack_code_reg & ~ACK_FLAG) : 16'd0;
            ack_ok_reg    <= frame_is_ack_reg && (ack_status_reg == 16'd0);
            last_reg      <= 1'b1;
        end
        else if (cmd.load_target)
        begin
            kind_reg      <= 1'b0;
            alarm_reg     <= stored_alarm_reg;
            total_out_reg <= 4'(total_reg);
            slot_out_reg  <= 3'(slot_reg);
            angle_reg     <= ram_rd_data[7:0] ^ ANGLE_BIAS;
            distance_reg  <= ram_rd_data[15:8];
            heading_reg   <= ram_rd_data[23:16];
            speed_reg     <= ram_rd_data[31:24];
            snr_reg       <= ram_rd_data[39:32];
            ack_cmd_reg   <= 16'd0;
            ack_ok_reg    <= 1'b0;
            last_reg      <= sts.last_slot;
        end
    end

    assign rpt_valid     = out_valid_reg;
    assign frame_kind    = kind_reg;
    assign alarm_flag    = alarm_reg;
    assign target_total  = total_out_reg;
    assign target_slot   = slot_out_reg;
    assign target_angle  = $signed(angle_reg);
    assign target_range  = distance_reg;
    assign heading_code  = heading_reg;
    assign target_speed  = speed_reg;
    assign snr_value     = snr_reg;
    assign ack_command   = ack_cmd_reg;
    assign ack_ok        = ack_ok_reg;
    assign last_of_frame = last_reg;

endmodule

### design/radar_report_frame_parser.sv
// ---------------------------------------------------------------------------
// radar_report_frame_parser
// Serial byte stream parser for radar acknowledge and target report frames.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while hunting and collecting a frame.
// After the last tail byte, input stalls while one result is loaded for an
// acknowledge or empty report, or a store read and then a result load for
// each target, waiting while rpt_stall holds; rpt_valid is set by each load.
// Reset: rst_n clears parser state and result valid at once; the target store
// is not cleared, only targets written in the current frame are read.
// ---------------------------------------------------------------------------
module radar_report_frame_parser #(
    parameter int MAX_TARGETS     = 8,
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    // byte input channel
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    // result channel
    output logic              rpt_valid,
    input  logic              rpt_stall,
    output logic              frame_kind,
    output logic              alarm_flag,
    output logic [3:0]        target_total,
    output logic [2:0]        target_slot,
    output logic signed [7:0] target_angle,
    output logic [7:0]        target_range,
    output logic [7:0]        heading_code,
    output logic [7:0]        target_speed,
    output logic [7:0]        snr_value,
    output logic [15:0]       ack_command,
    output logic              ack_ok,
    output logic              last_of_frame
);
    import rrfp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: walks hunt, length, body and tail phases, then sequences
    // result emission. It owns the input stall.
    rrfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: header and tail windows, length and position counters,
    // target store and the result register, which holds a finished
    // transaction while the next bytes are taken.
    rrfp_dp #(
        .MAX_TARGETS     (MAX_TARGETS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .sts           (sts),
        .rpt_stall     (rpt_stall),
        .rpt_valid     (rpt_valid),
        .frame_kind    (frame_kind),
        .alarm_flag    (alarm_flag),
        .target_total  (target_total),
        .target_slot   (target_slot),
        .target_angle  (target_angle),
        .target_range  (target_range),
        .heading_code  (heading_code),
        .target_speed  (target_speed),
        .snr_value     (snr_value),
        .ack_command   (ack_command),
        .ack_ok        (ack_ok),
        .last_of_frame (last_of_frame)
    );

endmodule

### tb/tb_radar_report_frame_parser.sv
// ---------------------------------------------------------------------------
// tb_radar_report_frame_parser
// Self-checking bench: drives serial byte streams (directed frames, then
// random frames and noise) into the parser, predicts every acknowledge and
// target report, and compares each accepted report against the prediction.
// ---------------------------------------------------------------------------
module tb_radar_report_frame_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TGT_SLOTS        = 8;
    localparam int FRAME_BYTE_LIMIT = 256;
    localparam int N_ROWS           = 22;

    // One report as it leaves the parser, in port order
    typedef struct packed {
        logic        frame_kind;
        logic        alarm_flag;
        logic [3:0]  target_total;
        logic [2:0]  target_slot;
        logic [7:0]  target_angle;
        logic [7:0]  target_range;
        logic [7:0]  heading_code;
        logic [7:0]  target_speed;
        logic [7:0]  snr_value;
        logic [15:0] ack_command;
        logic        ack_ok;
        logic        last_of_frame;
    } report_t;

    localparam report_t NO_REPORT = '0;

    typedef enum logic [1:0] {ROW_RAW, ROW_ACK, ROW_DATA} row_kind_t;
    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_RAMP} fill_t;

    // One stimulus row: a complete frame, or a run of raw bytes.
    //   skip : leading header bytes to omit (header already shifted in)
    //   lead : ack {status, command}, data {alarm, count}; little-endian body start
    //   tail : 0 sends the proper tail, anything else is sent as the tail
    //   typed: push 'want' instead of the predicted reports
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  skip;
        logic [15:0] len;
        logic [31:0] lead;
        fill_t       fill;
        logic [31:0] tail;
        logic [3:0]  raw_n;
        logic [63:0] raw;
        logic        typed;
        report_t     want;
    } row_t;

    // Predictor phases
    typedef enum logic [2:0] {SCAN_SEEK, SCAN_LEN_LO, SCAN_LEN_HI, SCAN_BODY, SCAN_TAIL} scan_t;

    // Directed rows. Reports typed in below follow directly from the frame
    // layout; the rest go through the predictor.
    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        // noise with partial headers
        '{ROW_RAW, 2'd0, 16'd0, 32'h0, FILL_ZERO, 32'h0, 4'd6, 64'h0000_00FF_F4F3_FDFC,
          1'b0, NO_REPORT},
        // acknowledge with empty body: command zero, status reads as zero
        '{ROW_ACK, 2'd0, 16'd0, 32'h0, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b1, 1'b0, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1}},
        // all-ones command, nonzero status
        '{ROW_ACK, 2'd0, 16'd4, 32'h0001_FFFF, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b1, 1'b0, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFEFF, 1'b0, 1'b1}},
        // short acknowledge body: status bytes missing
        '{ROW_ACK, 2'd0, 16'd2, 32'h0000_01A5, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b1, 1'b0, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h00A5, 1'b1, 1'b1}},
        // long acknowledge body beyond the data frame limit
        '{ROW_ACK, 2'd0, 16'd300, 32'h0000_0102, FILL_RAND, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b1, 1'b0, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0002, 1'b1, 1'b1}},
        // data frame with empty body
        '{ROW_DATA, 2'd0, 16'd0, 32'h0, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b0, 1'b0, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1}},
        // count only, alarm missing, no room for a target
        '{ROW_DATA, 2'd0, 16'd1, 32'h0000_0005, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b0, 1'b0, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1}},
        // count and alarm, no room for a target
        '{ROW_DATA, 2'd0, 16'd2, 32'h0000_8003, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b0, 1'b1, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1}},
        // one all-zero target: most negative angle
        '{ROW_DATA, 2'd0, 16'd7, 32'h0000_0001, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b0, 1'b0, 4'd1, 3'd0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1}},
        // one all-ones target: most positive angle
        '{ROW_DATA, 2'd0, 16'd7, 32'h0000_FF01, FILL_ONES, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b0, 1'b1, 4'd1, 3'd0, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b0, 1'b1}},
        // count larger than the body holds
        '{ROW_DATA, 2'd0, 16'd12, 32'h0000_0003, FILL_RAMP, 32'h0, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        // largest data frame: count clamped to the slot limit, extra targets ignored
        '{ROW_DATA, 2'd0, 16'd246, 32'h0000_01FF, FILL_RAND, 32'h0, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        // nine targets in the body, clamp to the slot limit
        '{ROW_DATA, 2'd0, 16'd47, 32'h0000_0009, FILL_RAMP, 32'h0, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        // one byte over the limit: dropped at the length high byte
        '{ROW_DATA, 2'd0, 16'd247, 32'h0000_0001, FILL_RAND, 32'h0, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        // overlong, and the length high byte opens the next header
        '{ROW_DATA, 2'd0, 16'hF40A, 32'h0, FILL_RAND, 32'h0, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        '{ROW_DATA, 2'd1, 16'd7, 32'h0000_0001, FILL_RAND, 32'h0, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        // bad data tail whose last byte opens an acknowledge header
        '{ROW_DATA, 2'd0, 16'd7, 32'h0000_0001, FILL_RAND, 32'hF8F7_F6FD, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        '{ROW_ACK, 2'd1, 16'd4, 32'h0000_0100, FILL_ZERO, 32'h0, 4'd0, 64'h0, 1'b1,
          '{1'b1, 1'b0, 4'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1}},
        // bad acknowledge tail whose last byte opens a data header
        '{ROW_ACK, 2'd0, 16'd4, 32'h1234_0155, FILL_ZERO, 32'h0403_02F4, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        '{ROW_DATA, 2'd1, 16'd22, 32'h0000_0104, FILL_RAND, 32'h0, 4'd0, 64'h0,
          1'b0, NO_REPORT},
        // repeated first header byte, empty body, tail sent as a separate run
        '{ROW_RAW, 2'd0, 16'd0, 32'h0, FILL_ZERO, 32'h0, 4'd7, 64'h00F4_F4F3_F2F1_0000,
          1'b0, NO_REPORT},
        '{ROW_RAW, 2'd0, 16'd0, 32'h0, FILL_ZERO, 32'h0, 4'd4, 64'h0000_0000_F8F7_F6F5,
          1'b0, NO_REPORT}
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              rx_valid  = 1'b0;
    logic              rx_stall;
    logic [7:0]        rx_byte   = 8'h00;
    logic              rpt_valid;
    logic              rpt_stall = 1'b0;
    logic              frame_kind;
    logic              alarm_flag;
    logic [3:0]        target_total;
    logic [2:0]        target_slot;
    logic signed [7:0] target_angle;
    logic [7:0]        target_range;
    logic [7:0]        heading_code;
    logic [7:0]        target_speed;
    logic [7:0]        snr_value;
    logic [15:0]       ack_command;
    logic              ack_ok;
    logic              last_of_frame;

    // Predictor state
    scan_t       scan_phase = SCAN_SEEK;
    logic [31:0] head_win   = '0;
    logic        in_ack     = 1'b0;
    logic [15:0] body_len   = '0;
    logic [15:0] body_pos   = '0;
    logic [39:0] tgt_mem [TGT_SLOTS];
    logic [7:0]  tgt_count  = '0;
    logic        tgt_alarm  = 1'b0;
    logic [15:0] ack_code   = '0;
    logic [15:0] ack_status = '0;
    logic [31:0] tail_win   = '0;

    report_t expected_reports [$];
    logic    typed_row   = 1'b0;
    logic    sender_calm = 1'b0;
    logic    recv_calm   = 1'b0;
    int      stall_left  = 0;
    int      predicted   = 0;
    int      sent_bytes  = 0;
    int      mismatches  = 0;

    radar_report_frame_parser #(
        .MAX_TARGETS     (TGT_SLOTS),
        .MAX_FRAME_BYTES (FRAME_BYTE_LIMIT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .rpt_valid     (rpt_valid),
        .rpt_stall     (rpt_stall),
        .frame_kind    (frame_kind),
        .alarm_flag    (alarm_flag),
        .target_total  (target_total),
        .target_slot   (target_slot),
        .target_angle  (target_angle),
        .target_range  (target_range),
        .heading_code  (heading_code),
        .target_speed  (target_speed),
        .snr_value     (snr_value),
        .ack_command   (ack_command),
        .ack_ok        (ack_ok),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // Hold the predicted report, unless the current row carries its own.
    function automatic void queue_report(input report_t r);
        predicted++;
        if (!typed_row)
            expected_reports.push_back(r);
    endfunction

    // Advance the frame predictor by one accepted byte and queue the reports
    // that the byte completes.
    function automatic void track_byte(input logic [7:0] b);
        int      fit;
        int      total;
        int      slot;
        int      lane;
        report_t r;
        r = NO_REPORT;
        case (scan_phase)
            SCAN_LEN_LO:
            begin
                body_len    = {8'h00, b};
                scan_phase  = SCAN_LEN_HI;
            end
            SCAN_LEN_HI:
            begin
                body_len[15:8] = b;
                if (!in_ack && 10 + int'(body_len) > FRAME_BYTE_LIMIT)
                begin
                    // Drop the overlong data frame; rescan from this byte.
                    scan_phase = SCAN_SEEK;
                    head_win   = {24'h0, b};
                end
                else
                begin
                    body_pos   = '0;
                    tail_win   = '0;
                    scan_phase = (body_len == 16'd0) ? SCAN_TAIL : SCAN_BODY;
                end
            end
            SCAN_BODY:
            begin
                if (in_ack)
                begin
                    case (body_pos)
                        16'd0: ack_code[7:0]    = b;
                        16'd1: ack_code[15:8]   = b;
                        16'd2: ack_status[7:0]  = b;
                        16'd3: ack_status[15:8] = b;
                        default: ;
                    endcase
                end
                else if (body_pos == 16'd0)
                    tgt_count = b;
                else if (body_pos == 16'd1)
                    tgt_alarm = (b != 8'h00);
                else
                begin
                    slot = (int'(body_pos) - 2) / 5;
                    lane = (int'(body_pos) - 2) % 5;
                    if (slot < TGT_SLOTS)
                        tgt_mem[slot][lane * 8 +: 8] = b;
                end
                body_pos++;
                if (body_pos >= body_len)
                begin
                    body_pos   = '0;
                    scan_phase = SCAN_TAIL;
                end
            end
            SCAN_TAIL:
            begin
                tail_win = {tail_win[23:0], b};
                body_pos++;
                if (body_pos >= 16'd4)
                begin
                    body_pos   = '0;
                    scan_phase = SCAN_SEEK;
                    if (tail_win != (in_ack ? rrfp_pkg::ACK_TAIL : rrfp_pkg::DAT_TAIL))
                        head_win = {24'h0, b};
                    else if (in_ack)
                    begin
                        head_win        = '0;
                        r.frame_kind    = 1'b1;
                        r.ack_command   = ack_code & ~rrfp_pkg::ACK_FLAG;
                        r.ack_ok        = (ack_status == 16'h0000);
                        r.last_of_frame = 1'b1;
                        queue_report(r);
                    end
                    else
                    begin
                        head_win = '0;
                        // Clamp the count to the slots and to what the body holds.
                        fit   = (body_len >= 16'd2) ? (int'(body_len) - 2) / 5 : 0;
                        total = int'(tgt_count);
                        if (total > TGT_SLOTS)
                            total = TGT_SLOTS;
                        if (total > fit)
                            total = fit;
                        r.alarm_flag = tgt_alarm;
                        if (total == 0)
                        begin
                            r.last_of_frame = 1'b1;
                            queue_report(r);
                        end
                        for (int i = 0; i < total; i++)
                        begin
                            r.target_total  = 4'(total);
                            r.target_slot   = 3'(i);
                            r.target_angle  = tgt_mem[i][7:0] ^ rrfp_pkg::ANGLE_BIAS;
                            r.target_range  = tgt_mem[i][15:8];
                            r.heading_code  = tgt_mem[i][23:16];
                            r.target_speed  = tgt_mem[i][31:24];
                            r.snr_value     = tgt_mem[i][39:32];
                            r.last_of_frame = (i == total - 1);
                            queue_report(r);
                        end
                    end
                end
            end
            default:
            begin
                head_win = {head_win[23:0], b};
                if (head_win == rrfp_pkg::ACK_HEAD || head_win == rrfp_pkg::DAT_HEAD)
                begin
                    in_ack     = (head_win == rrfp_pkg::ACK_HEAD);
                    tgt_count  = '0;
                    tgt_alarm  = 1'b0;
                    ack_code   = '0;
                    ack_status = '0;
                    body_pos   = '0;
                    scan_phase = SCAN_LEN_LO;
                end
            end
        endcase
    endfunction

    function automatic string fmt_report(input report_t r);
        return $sformatf({"kind=%0d alarm=%0d total=%0d slot=%0d angle=%02h dist=%02h",
                          " dir=%02h speed=%02h snr=%02h cmd=%04h ok=%0d last=%0d"},
                         r.frame_kind, r.alarm_flag, r.target_total, r.target_slot,
                         r.target_angle, r.target_range, r.heading_code, r.target_speed,
                         r.snr_value, r.ack_command, r.ack_ok, r.last_of_frame);
    endfunction

    // Offer one byte after a random gap (none when calm), hold it until the
    // transaction completes, then advance the predictor.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall !== 1'b0)
            @(posedge clk);
        track_byte(b);
        sent_bytes++;
    endtask

    // Send one row: header (minus skipped bytes), length, body and tail, or
    // a run of raw bytes. Overlong data frames stop after the length.
    task automatic send_row(input row_t row);
        logic [31:0] head;
        logic [31:0] tail;
        logic [7:0]  bv;
        typed_row = row.typed;
        if (row.kind == ROW_RAW)
        begin
            for (int k = 0; k < int'(row.raw_n); k++)
                send_byte(row.raw[8 * (int'(row.raw_n) - 1 - k) +: 8]);
        end
        else
        begin
            head = (row.kind == ROW_ACK) ? rrfp_pkg::ACK_HEAD : rrfp_pkg::DAT_HEAD;
            tail = (row.kind == ROW_ACK) ? rrfp_pkg::ACK_TAIL : rrfp_pkg::DAT_TAIL;
            if (row.tail != 32'h0)
                tail = row.tail;
            for (int k = int'(row.skip); k < 4; k++)
                send_byte(head[8 * (3 - k) +: 8]);
            send_byte(row.len[7:0]);
            send_byte(row.len[15:8]);
            if (!(row.kind == ROW_DATA && 10 + int'(row.len) > FRAME_BYTE_LIMIT))
            begin
                for (int k = 0; k < int'(row.len); k++)
                begin
                    if (k < ((row.kind == ROW_ACK) ? 4 : 2))
                        bv = row.lead[8 * k +: 8];
                    else
                    begin
                        case (row.fill)
                            FILL_ZERO: bv = 8'h00;
                            FILL_ONES: bv = 8'hFF;
                            FILL_RAMP: bv = 8'(k);
                            default:   bv = 8'($urandom);
                        endcase
                    end
                    send_byte(bv);
                end
                for (int k = 0; k < 4; k++)
                    send_byte(tail[8 * (3 - k) +: 8]);
            end
        end
        if (row.typed)
            expected_reports.push_back(row.want);
        typed_row = 1'b0;
    endtask

    // Drop valid and hold off until every expected report has arrived.
    task automatic drain_reports();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // Report side: check each accepted report against the oldest expectation,
    // then draw the stall for the next one. Calm stretches use no stall.
    always @(posedge clk)
    begin
        report_t seen;
        report_t want;
        if (rst_n && rpt_valid && !rpt_stall)
        begin
            seen = '{frame_kind, alarm_flag, target_total, target_slot, target_angle,
                     target_range, heading_code, target_speed, snr_value, ack_command,
                     ack_ok, last_of_frame};
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected report %s", fmt_report(seen));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: report mismatch at %0t", $realtime);
                        $display("  expected %s", fmt_report(want));
                        $display("  actual   %s", fmt_report(seen));
                    end
                end
            end
            stall_left = recv_calm ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0)
                recv_calm = !recv_calm;
        end
        if (stall_left > 0)
        begin
            rpt_stall <= 1'b1;
            stall_left--;
        end
        else
            rpt_stall <= 1'b0;
    end

    // Stimulus: reset, directed rows, then random frames and noise.
    initial
    begin
        row_t rnd_row;
        int   pick;
        foreach (tgt_mem[i])
            tgt_mem[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            send_row(DIRECTED_ROWS[i]);
        end
        drain_reports();

        // Mostly well-formed frames with random content; some noise and
        // broken tails. Keep going until enough bytes are sent and reports predicted.
        while (sent_bytes < 120 || predicted < 48)
        begin
            rnd_row     = '0;
            rnd_row.fill = FILL_RAND;
            pick        = $urandom_range(0, 99);
            if (pick < 10)
            begin
                rnd_row.kind  = ROW_RAW;
                rnd_row.raw_n = 4'($urandom_range(1, 8));
                rnd_row.raw   = {$urandom, $urandom};
            end
            else if (pick < 35)
            begin
                rnd_row.kind = ROW_ACK;
                rnd_row.len  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 40))
                                                           : 16'($urandom_range(0, 4));
                rnd_row.lead = $urandom;
                if ($urandom_range(0, 1) == 1)
                    rnd_row.lead[31:16] = 16'h0000;
            end
            else
            begin
                rnd_row.kind = ROW_DATA;
                case ($urandom_range(0, 19))
                    0:       rnd_row.len = 16'd246;
                    1, 2:    rnd_row.len = 16'($urandom_range(0, 255));
                    default: rnd_row.len = 16'(2 + 5 * $urandom_range(0, 9)
                                               + $urandom_range(0, 4));
                endcase
                rnd_row.lead[7:0]  = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 10));
                rnd_row.lead[15:8] = ($urandom_range(0, 1) == 0) ? 8'h00
                                                                 : 8'($urandom_range(1, 255));
            end
            // Break about one tail in ten by flipping a single bit.
            if (rnd_row.kind != ROW_RAW && $urandom_range(0, 9) == 0)
                rnd_row.tail = ((rnd_row.kind == ROW_ACK) ? rrfp_pkg::ACK_TAIL
                                                          : rrfp_pkg::DAT_TAIL)
                               ^ (32'h1 << $urandom_range(0, 31));
            sender_calm = ($urandom_range(0, 3) == 0);
            send_row(rnd_row);
            if ($urandom_range(0, 9) == 0)
                drain_reports();
        end

        drain_reports();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
